@@ rtl/core/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int CFG_W  = 16;
	localparam int LEN_W  = 16;
	localparam int NEED_W = 22;
	localparam int PCT_W  = 7;
	localparam int NREGS  = 2;

	localparam logic [CFG_W-1:0] POOL0_RESET = 16'd3200;
	localparam logic [CFG_W-1:0] POOL1_RESET = 16'd30720;
	localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;

	typedef enum logic [1:0] {
		FN_ALLOC  = 2'd0,
		FN_FREE   = 2'd1,
		FN_RESIZE = 2'd2,
		FN_QUERY  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERO    = 2'd1,
		ST_NORUN   = 2'd2,
		ST_NOALLOC = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LEN_RD,
		S_LEN_CHK,
		S_SCAN,
		S_MARK,
		S_FREE,
		S_RL_CLR,
		S_FINISH,
		S_DIV,
		S_RESP
	} state_t;

endpackage

@@ rtl/core/bitmap_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// First-fit, top-down block allocator over a usage bitmap and a run-length
// table kept in on-chip memories.
//
// After reset the block clears all POOLS*BLOCKS entries (65536 by default) of
// both memories before it takes its first word. Allocate, free and resize
// requests then walk the bitmap one block per cycle. An allocate scans down
// from the top of the pool and marks the blocks it claims, a free clears
// the blocks of a run, and a resize does both; a usage query runs through
// a one-bit-per-cycle divider. One request is in work at a time; a finished
// result waits in the output register without stalling the input side.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit #(
	parameter int BLOCKS      = 32768,
	parameter int POOLS       = 2,
	parameter int BLOCK_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // size_bytes[20:0], block_index[35:21], zero pad
	input  logic [2:0]  s_tuser,   // func[1:0], pool[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // start_block[14:0], used_percent[21:15], zero pad
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int KW     = $clog2(BLOCKS + 1);
	localparam int DEPTH  = POOLS * BLOCKS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CW     = (KW > bba_pkg::LEN_W) ? KW : bba_pkg::LEN_W;
	localparam int UW     = CW + 1;
	localparam int DIV_W  = KW + bba_pkg::PCT_W;
	localparam int NW     = bba_pkg::NEED_W;

	logic             used_map [DEPTH];
	logic [bba_pkg::LEN_W-1:0] run_len [DEPTH];

	bba_pkg::state_t  state_q, state_d;
	logic [bba_pkg::CFG_W-1:0] cfg_q [bba_pkg::NREGS];
	logic [KW-1:0]    used_q [bba_pkg::NREGS];
	logic [ADDR_W-1:0] clr_q;
	logic             vld_s1;
	logic [KW-1:0]    b_s1;
	logic             um_rd_q;
	logic [bba_pkg::LEN_W-1:0] rl_rd_q;

	bba_pkg::func_t   func_q;
	logic             pool_q;
	logic             fr_q;
	logic [NW-1:0]    need_q;
	logic [14:0]      idx_q;
	logic [ADDR_W-1:0] base_q;
	logic [KW-1:0]    lim_q;
	logic [KW-1:0]    k_q;
	logic [CW-1:0]    cnt_q;
	logic [bba_pkg::LEN_W-1:0] len_q;
	logic [KW-1:0]    start_q;
	bba_pkg::status_t status_q;
	logic [bba_pkg::PCT_W-1:0] pct_q;
	logic [DIV_W-1:0] rem_q;
	logic [2:0]       step_q;

	logic             m_tvalid_q;
	logic [1:0]       m_status_q;
	logic [14:0]      m_start_q;
	logic [bba_pkg::PCT_W-1:0] m_pct_q;

	bba_pkg::func_t   in_func;
	logic             in_pool;
	logic [20:0]      in_size;
	logic [14:0]      in_idx;
	logic [NW-1:0]    in_need;
	logic [KW-1:0]    in_lim;
	logic             in_pool_ok;
	logic             in_idx_ok;
	logic             accept;

	logic [ADDR_W-1:0] um_raddr, rl_raddr;
	logic             um_we, rl_we, um_wdata;
	logic [ADDR_W-1:0] um_waddr, rl_waddr;
	logic [bba_pkg::LEN_W-1:0] rl_wdata;

	logic [CW-1:0]    cnt_n;
	logic             found;
	logic [DIV_W-1:0] div_sub;
	logic [UW-1:0]    used_sum, used_take, used_new;
	logic             resp_load;

	assign in_func    = bba_pkg::func_t'(s_tuser[1:0]);
	assign in_pool    = s_tuser[2];
	assign in_size    = s_tdata[20:0];
	assign in_idx     = s_tdata[35:21];
	assign in_need    = NW'(({1'b0, in_size} + NW'(BLOCK_BYTES - 1)) / BLOCK_BYTES);
	assign in_lim     = (32'(cfg_q[in_pool]) > BLOCKS) ? KW'(BLOCKS) : KW'(cfg_q[in_pool]);
	assign in_pool_ok = 32'(in_pool) < POOLS;
	assign in_idx_ok  = 32'(in_idx) < BLOCKS;
	assign s_tready   = (state_q == bba_pkg::S_IDLE);
	assign accept     = s_tvalid && s_tready;

	assign um_raddr  = base_q + ADDR_W'(k_q - KW'(1));
	assign rl_raddr  = base_q + ADDR_W'(idx_q);
	assign cnt_n     = um_rd_q ? '0 : cnt_q + CW'(1);
	assign found     = vld_s1 && (NW'(cnt_n) == need_q);
	assign div_sub   = DIV_W'(lim_q) << step_q;
	assign resp_load = !m_tvalid_q || m_tready;

	assign used_sum  = UW'(used_q[pool_q]) + (fr_q ? '0 : UW'(need_q));
	assign used_take = (fr_q || func_q == bba_pkg::FN_RESIZE) ? UW'(len_q) : '0;
	assign used_new  = (used_sum >= used_take) ? used_sum - used_take : '0;

	always_comb begin
		state_d  = state_q;
		um_we    = 1'b0;
		um_waddr = base_q + ADDR_W'(k_q);
		um_wdata = 1'b0;
		rl_we    = 1'b0;
		rl_waddr = base_q + ADDR_W'(start_q);
		rl_wdata = bba_pkg::LEN_W'(need_q);
		unique case (state_q)
			bba_pkg::S_CLEAR: begin
				um_we    = 1'b1;
				um_waddr = clr_q;
				rl_we    = 1'b1;
				rl_waddr = clr_q;
				rl_wdata = '0;
				if (32'(clr_q) == DEPTH - 1) begin
					state_d = bba_pkg::S_IDLE;
				end
			end
			bba_pkg::S_IDLE: begin
				if (accept) begin
					case (in_func)
						bba_pkg::FN_ALLOC: begin
							if (in_size == '0 || !in_pool_ok || in_need > NW'(in_lim)) begin
								state_d = bba_pkg::S_RESP;
							end else begin
								state_d = bba_pkg::S_SCAN;
							end
						end
						bba_pkg::FN_FREE, bba_pkg::FN_RESIZE: begin
							if (!in_pool_ok || !in_idx_ok) begin
								state_d = bba_pkg::S_RESP;
							end else begin
								state_d = bba_pkg::S_LEN_RD;
							end
						end
						default: begin
							if (!in_pool_ok || in_lim == '0 || used_q[in_pool] >= in_lim) begin
								state_d = bba_pkg::S_RESP;
							end else begin
								state_d = bba_pkg::S_DIV;
							end
						end
					endcase
				end
			end
			bba_pkg::S_LEN_RD: begin
				state_d = bba_pkg::S_LEN_CHK;
			end
			bba_pkg::S_LEN_CHK: begin
				if (rl_rd_q == '0) begin
					state_d = bba_pkg::S_RESP;
				end else if (fr_q) begin
					state_d = bba_pkg::S_FREE;
				end else if (need_q > NW'(lim_q)) begin
					state_d = bba_pkg::S_RESP;
				end else begin
					state_d = bba_pkg::S_SCAN;
				end
			end
			bba_pkg::S_SCAN: begin
				if (found) begin
					state_d = bba_pkg::S_MARK;
				end else if (!vld_s1 && k_q == '0) begin
					state_d = bba_pkg::S_RESP;
				end
			end
			bba_pkg::S_MARK: begin
				um_we    = 1'b1;
				um_wdata = 1'b1;
				if (cnt_q == CW'(1)) begin
					state_d = (func_q == bba_pkg::FN_ALLOC) ? bba_pkg::S_FINISH : bba_pkg::S_FREE;
				end
			end
			bba_pkg::S_FREE: begin
				um_we = 1'b1;
				if (cnt_q == CW'(1) || 32'(k_q) == BLOCKS - 1) begin
					state_d = bba_pkg::S_RL_CLR;
				end
			end
			bba_pkg::S_RL_CLR: begin
				rl_we    = 1'b1;
				rl_waddr = base_q + ADDR_W'(idx_q);
				rl_wdata = '0;
				state_d  = bba_pkg::S_FINISH;
			end
			bba_pkg::S_FINISH: begin
				rl_we   = !fr_q;
				state_d = bba_pkg::S_RESP;
			end
			bba_pkg::S_DIV: begin
				if (step_q == '0) begin
					state_d = bba_pkg::S_RESP;
				end
			end
			bba_pkg::S_RESP: begin
				if (resp_load) begin
					state_d = bba_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bba_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (um_we) begin
			used_map[um_waddr] <= um_wdata;
		end
		um_rd_q <= used_map[um_raddr];
		if (rl_we) begin
			run_len[rl_waddr] <= rl_wdata;
		end
		rl_rd_q <= run_len[rl_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0]   <= bba_pkg::POOL0_RESET;
			cfg_q[1]   <= bba_pkg::POOL1_RESET;
			used_q[0]  <= '0;
			used_q[1]  <= '0;
			clr_q      <= '0;
			vld_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q[cfg_index] <= cfg_data;
			end
			if (state_q == bba_pkg::S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			vld_s1 <= (state_q == bba_pkg::S_SCAN) && !found && (k_q != '0);
			if (state_q == bba_pkg::S_FINISH) begin
				used_q[pool_q] <= KW'(used_new);
			end
			if (state_q == bba_pkg::S_RESP && resp_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bba_pkg::S_IDLE: begin
				func_q   <= in_func;
				pool_q   <= in_pool;
				fr_q     <= (in_func == bba_pkg::FN_FREE) ||
					    (in_func == bba_pkg::FN_RESIZE && in_size == '0);
				need_q   <= in_need;
				idx_q    <= in_idx;
				base_q   <= ADDR_W'(in_pool) * ADDR_W'(BLOCKS);
				lim_q    <= in_lim;
				k_q      <= in_lim;
				cnt_q    <= '0;
				start_q  <= '0;
				pct_q    <= '0;
				rem_q    <= DIV_W'(used_q[in_pool]) * DIV_W'(bba_pkg::PCT_FULL);
				step_q   <= 3'(bba_pkg::PCT_W - 1);
				status_q <= bba_pkg::ST_OK;
				case (in_func)
					bba_pkg::FN_ALLOC: begin
						if (in_size == '0) begin
							status_q <= bba_pkg::ST_ZERO;
						end else if (!in_pool_ok || in_need > NW'(in_lim)) begin
							status_q <= bba_pkg::ST_NORUN;
						end
					end
					bba_pkg::FN_FREE, bba_pkg::FN_RESIZE: begin
						if (!in_pool_ok || !in_idx_ok) begin
							status_q <= bba_pkg::ST_NOALLOC;
						end
					end
					default: begin
						if (in_pool_ok && in_lim != '0 && used_q[in_pool] >= in_lim) begin
							pct_q <= bba_pkg::PCT_FULL;
						end
					end
				endcase
			end
			bba_pkg::S_LEN_CHK: begin
				len_q <= rl_rd_q;
				k_q   <= KW'(idx_q);
				cnt_q <= CW'(rl_rd_q);
				if (rl_rd_q == '0) begin
					status_q <= bba_pkg::ST_NOALLOC;
				end else if (!fr_q) begin
					k_q   <= lim_q;
					cnt_q <= '0;
					if (need_q > NW'(lim_q)) begin
						status_q <= bba_pkg::ST_NORUN;
					end
				end
			end
			bba_pkg::S_SCAN: begin
				if (k_q != '0) begin
					k_q <= k_q - KW'(1);
				end
				b_s1 <= k_q - KW'(1);
				if (vld_s1) begin
					cnt_q <= cnt_n;
				end
				if (found) begin
					start_q <= b_s1;
					k_q     <= b_s1;
					cnt_q   <= CW'(need_q);
				end else if (!vld_s1 && k_q == '0) begin
					status_q <= bba_pkg::ST_NORUN;
				end
			end
			bba_pkg::S_MARK: begin
				k_q   <= k_q + KW'(1);
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					k_q   <= KW'(idx_q);
					cnt_q <= CW'(len_q);
				end
			end
			bba_pkg::S_FREE: begin
				k_q   <= k_q + KW'(1);
				cnt_q <= cnt_q - CW'(1);
			end
			bba_pkg::S_FINISH: begin
				if (fr_q) begin
					start_q <= '0;
				end
			end
			bba_pkg::S_DIV: begin
				if (rem_q >= div_sub) begin
					rem_q         <= rem_q - div_sub;
					pct_q[step_q] <= 1'b1;
				end
				step_q <= step_q - 3'd1;
			end
			bba_pkg::S_RESP: begin
				if (resp_load) begin
					m_status_q <= status_q;
					m_start_q  <= 15'(start_q);
					m_pct_q    <= pct_q;
				end
			end
			default: begin
				b_s1 <= b_s1;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {2'b00, m_pct_q, m_start_q};

	// A pool never counts more blocks in use than BLOCKS.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(used_q[0]) <= BLOCKS) && (32'(used_q[1]) <= BLOCKS))
		else $error("used block count exceeds pool capacity");

	// A failed request never reports a start block.
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != bba_pkg::ST_OK) |-> (m_tdata[14:0] == '0))
		else $error("start block set on a failed request");

	// No word is taken while the memories are being cleared.
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bba_pkg::S_CLEAR) |-> !s_tready)
		else $error("input accepted during the clearing pass");

	// A claimed run is written only after a scan has found it free.
	a_mark_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bba_pkg::S_MARK) && ($past(state_q) != bba_pkg::S_MARK) |->
		($past(state_q) == bba_pkg::S_SCAN))
		else $error("run marked without a completed scan");

endmodule

@@ tb/tb_bitmap_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator_unit
// Self-checking testbench for the bitmap block allocator. A behavioral copy
// of the bitmap, the run-length table and the usage counters predicts the
// status, start block and usage percentage of every request. Directed and
// random allocate, free, resize and query words run under several pool
// sizes, with random idling on both stream sides except in the last run.
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator_unit;

	localparam int NBLK  = 32768;
	localparam int LIMIT = 20000000;

	typedef struct {
		bba_pkg::status_t st;
		logic [14:0] start;
		logic [6:0]  pct;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	bit          blk_used [2*NBLK];
	logic [15:0] blk_len [2*NBLK];
	int unsigned pool_used [2];
	int unsigned pool_cfg [2];
	answer_t     answer_q [$];
	int          live_runs [$];
	bit          quiet = 1'b0;
	int          errors = 0;
	int          words_sent = 0;
	int          results_seen = 0;
	int          stall_left = 0;
	longint      cycles = 0;

	bitmap_block_allocator_unit u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned pool_limit(bit p);
		return (pool_cfg[p] > NBLK) ? NBLK : pool_cfg[p];
	endfunction

	function automatic bit find_free_run(bit p, int unsigned need, output int unsigned at);
		int unsigned run;
		run = 0;
		for (int k = pool_limit(p); k > 0; k--) begin
			if (!blk_used[p*NBLK + k - 1]) run++;
			else run = 0;
			if (run == need) begin
				at = k - 1;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void set_run(bit p, int unsigned s, int unsigned n, bit v);
		for (int unsigned i = 0; i < n && s + i < NBLK; i++) blk_used[p*NBLK + s + i] = v;
	endfunction

	function automatic void forget_run(bit p, int unsigned s);
		foreach (live_runs[i]) if (live_runs[i] == {p, s[14:0]}) begin
			live_runs.delete(i);
			return;
		end
	endfunction

	function automatic bba_pkg::status_t release_run(bit p, int unsigned idx);
		int unsigned len;
		len = 32'(blk_len[p*NBLK + idx]);
		if (len == 0) return bba_pkg::ST_NOALLOC;
		set_run(p, idx, len, 1'b0);
		blk_len[p*NBLK + idx] = '0;
		pool_used[p] = (pool_used[p] >= len) ? pool_used[p] - len : 0;
		forget_run(p, idx);
		return bba_pkg::ST_OK;
	endfunction

	function automatic answer_t predict_request(bba_pkg::func_t f, bit p, int unsigned sz,
			int unsigned idx);
		answer_t a;
		int unsigned need, s;
		longint q;
		a = '{bba_pkg::ST_OK, '0, '0};
		need = (sz + 31) / 32;
		case (f)
			bba_pkg::FN_ALLOC: begin
				if (sz == 0) a.st = bba_pkg::ST_ZERO;
				else if (need > pool_limit(p) || !find_free_run(p, need, s))
					a.st = bba_pkg::ST_NORUN;
				else begin
					set_run(p, s, need, 1'b1);
					blk_len[p*NBLK + s] = 16'(need);
					pool_used[p] += need;
					live_runs.push_back({p, s[14:0]});
					a.start = s[14:0];
				end
			end
			bba_pkg::FN_FREE: a.st = release_run(p, idx);
			bba_pkg::FN_RESIZE: begin
				if (sz == 0) a.st = release_run(p, idx);
				else if (blk_len[p*NBLK + idx] == 0) a.st = bba_pkg::ST_NOALLOC;
				else if (need > pool_limit(p) || !find_free_run(p, need, s))
					a.st = bba_pkg::ST_NORUN;
				else begin
					set_run(p, s, need, 1'b1);
					pool_used[p] += need;
					void'(release_run(p, idx));
					blk_len[p*NBLK + s] = 16'(need);
					live_runs.push_back({p, s[14:0]});
					a.start = s[14:0];
				end
			end
			default: begin
				if (pool_limit(p) != 0) begin
					q = longint'(pool_used[p]) * 100 / pool_limit(p);
					a.pct = (q > 100) ? bba_pkg::PCT_FULL : q[6:0];
				end
			end
		endcase
		return a;
	endfunction

	task automatic send_word(bba_pkg::func_t f, bit p, int unsigned sz, int unsigned idx);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		s_tdata = {4'b0, idx[14:0], sz[20:0]};
		s_tuser = {p, f};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		answer_q.push_back(predict_request(f, p, sz, idx));
		words_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_pool(bit p, int unsigned blocks);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = p;
		cfg_data = blocks[15:0];
		@(negedge clk);
		cfg_we = 1'b0;
		pool_cfg[p] = blocks & 16'hFFFF;
	endtask

	function automatic int unsigned pick_live();
		return live_runs[$urandom_range(0, live_runs.size() - 1)];
	endfunction

	task automatic test_directed();
		int unsigned r;
		send_word(bba_pkg::FN_ALLOC, 0, 0, 0);
		send_word(bba_pkg::FN_ALLOC, 0, 1, 0);
		send_word(bba_pkg::FN_ALLOC, 0, 33, 0);
		send_word(bba_pkg::FN_ALLOC, 1, 1048576, 0);
		send_word(bba_pkg::FN_ALLOC, 0, 2097151, 32767);
		send_word(bba_pkg::FN_ALLOC, 1, 64, 0);
		send_word(bba_pkg::FN_QUERY, 0, 0, 0);
		send_word(bba_pkg::FN_QUERY, 1, 0, 0);
		send_word(bba_pkg::FN_FREE, 0, 0, 32767);
		send_word(bba_pkg::FN_FREE, 1, 0, 21845);
		send_word(bba_pkg::FN_FREE, 0, 0, 10922);
		send_word(bba_pkg::FN_FREE, 0, 0, 3199);
		send_word(bba_pkg::FN_FREE, 0, 0, 3199);
		send_word(bba_pkg::FN_RESIZE, 0, 0, 3197);
		send_word(bba_pkg::FN_RESIZE, 1, 100, 5);
		send_word(bba_pkg::FN_RESIZE, 1, 200, 30718);
		r = pick_live();
		send_word(bba_pkg::FN_RESIZE, r[15], 1048576, r[14:0]);
		send_word(bba_pkg::FN_RESIZE, r[15], 32, r[14:0]);
		send_word(bba_pkg::FN_QUERY, 1, 0, 0);
	endtask

	task automatic test_saturation();
		write_pool(0, 64);
		send_word(bba_pkg::FN_ALLOC, 0, 1920, 0);
		write_pool(0, 8);
		send_word(bba_pkg::FN_QUERY, 0, 0, 0);
		send_word(bba_pkg::FN_ALLOC, 0, 32, 0);
		send_word(bba_pkg::FN_FREE, 0, 0, 4);
		send_word(bba_pkg::FN_QUERY, 0, 0, 0);
	endtask

	task automatic test_mixed(int n, bit wide);
		int unsigned r, k, sz;
		bit p;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			p = 1'($urandom_range(0, 1));
			sz = wide ? $urandom_range(1, 256) : $urandom_range(1, 768);
			if (r < 40) send_word(bba_pkg::FN_ALLOC, p, sz, $urandom_range(0, 32767));
			else if (r < 65 && live_runs.size() != 0) begin
				k = pick_live();
				send_word(bba_pkg::FN_FREE, k[15], $urandom_range(0, 2097151), k[14:0]);
			end else if (r < 78 && live_runs.size() != 0) begin
				k = pick_live();
				send_word(bba_pkg::FN_RESIZE, k[15], ($urandom_range(0, 9) == 0) ? 0 : sz,
					k[14:0]);
			end else if (r < 88) send_word(bba_pkg::FN_QUERY, p, $urandom_range(0, 2097151),
					$urandom_range(0, 32767));
			else if (wide) send_word($urandom_range(0, 1) ? bba_pkg::FN_FREE :
					bba_pkg::FN_RESIZE, p,
					$urandom_range(0, 2097151), $urandom_range(0, 32767));
			else send_word(bba_pkg::func_t'($urandom_range(0, 3)), p,
					$urandom_range(0, 2097151), $urandom_range(0, 32767));
		end
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready = 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 9);
			m_tready = 1'b0;
		end else begin
			m_tready = 1'b1;
		end
	end

	always @(posedge clk) begin
		answer_t a;
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (answer_q.size() == 0) begin
				$error("unexpected word: status %0d start %0d", m_tuser, m_tdata[14:0]);
				errors++;
			end else begin
				a = answer_q.pop_front();
				if (m_tuser != a.st) begin
					$error("status: expected %0d, got %0d", a.st, m_tuser);
					errors++;
				end
				if (m_tdata[14:0] != a.start) begin
					$error("start_block: expected %0d, got %0d", a.start, m_tdata[14:0]);
					errors++;
				end
				if (m_tdata[21:15] != a.pct) begin
					$error("used_percent: expected %0d, got %0d", a.pct, m_tdata[21:15]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[bitmap_block_allocator_unit] ERROR");
			$finish;
		end
	end

	initial begin
		foreach (blk_used[i]) begin
			blk_used[i] = 1'b0;
			blk_len[i] = '0;
		end
		pool_used = '{0, 0};
		pool_cfg = '{32'(bba_pkg::POOL0_RESET), 32'(bba_pkg::POOL1_RESET)};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_saturation();
		write_pool(0, 256);
		write_pool(1, 512);
		test_mixed(230, 1'b0);
		write_pool(0, 1);
		write_pool(1, 32768);
		test_mixed(120, 1'b1);
		write_pool(0, 4096);
		write_pool(1, 64);
		test_mixed(150, 1'b0);
		write_pool(0, 128);
		write_pool(1, 200);
		quiet = 1'b1;
		test_mixed(150, 1'b0);
		drain();
		if (answer_q.size() != 0) errors++;
		$display("Ran %0d words (%0d results) of allocate, free, resize and query",
			words_sent, results_seen);
		$display("over pool sizes from 1 to 32768 blocks, with stream idling on both sides.");
		if (errors == 0) begin
			$display("[bitmap_block_allocator_unit] OK");
		end else begin
			$display("[bitmap_block_allocator_unit] ERROR");
		end
		$finish;
	end

endmodule
